// ===== rtl/rpc_pkg.sv =====
package rpc_pkg;

	localparam int COORD_BITS = 20;
	localparam int SQ_VAL_BITS = 2 * COORD_BITS + 1;
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * COORD_BITS;
	localparam int MARGIN_BITS = COORD_BITS - 1;

	localparam int SQ_PER_STAGE = 3;
	localparam int SQ_STAGES = (ROOT_BITS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
	localparam int DV_PER_STAGE = 4;
	localparam int DV_STAGES = (COORD_BITS + DV_PER_STAGE - 1) / DV_PER_STAGE;
	localparam int LATENCY = 3 + SQ_STAGES + 1 + DV_STAGES + 1;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_EDGE_MARGIN = 2'd2,
		REG_FIRST_SIDE = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic [COORD_BITS-1:0] origin_x;
		logic [COORD_BITS-1:0] origin_y;
		logic [COORD_BITS-1:0] danger_x;
		logic [COORD_BITS-1:0] danger_y;
		logic [COORD_BITS-1:0] move_distance;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] result_x;
		logic [COORD_BITS-1:0] result_y;
	} out_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] ox;
		logic [COORD_BITS-1:0] oy;
		logic [COORD_BITS-1:0] move_dist;
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic                  sx;
		logic                  sy;
		logic                  side;
	} sq_side_t;

	typedef struct packed {
		logic [SQ_VAL_BITS-1:0] val;
		sq_side_t               side;
	} sq_in_t;

	typedef struct packed {
		logic [ROOT_BITS-1:0] len;
		sq_side_t             side;
	} sq_out_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] ox;
		logic [COORD_BITS-1:0] oy;
		logic                  sx;
		logic                  sy;
	} dv_side_t;

	typedef struct packed {
		logic [PROD_BITS-1:0] num_x;
		logic [PROD_BITS-1:0] num_y;
		logic [ROOT_BITS-1:0] len;
		dv_side_t             side;
	} dv_in_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] qx;
		logic [COORD_BITS-1:0] qy;
		dv_side_t              side;
	} dv_out_t;

endpackage

// ===== rtl/rpc_sqrt.sv =====
module rpc_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  rpc_pkg::sq_in_t in_data,
	output logic            out_valid,
	output rpc_pkg::sq_out_t out_data
);
	import rpc_pkg::*;

	localparam int VW = 2 * ROOT_BITS;
	localparam int RW = ROOT_BITS + 3;

	logic [RW-1:0]        rem_s  [0:SQ_STAGES];
	logic [ROOT_BITS-1:0] root_s [0:SQ_STAGES];
	logic [VW-1:0]        val_s  [0:SQ_STAGES];
	sq_side_t             side_s [0:SQ_STAGES];
	logic                 vld_s  [0:SQ_STAGES];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign val_s[0]  = {{(VW - SQ_VAL_BITS){1'b0}}, in_data.val};
	assign side_s[0] = in_data.side;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		logic [RW-1:0]        rem_n;
		logic [ROOT_BITS-1:0] root_n;
		logic [VW-1:0]        val_n;

		always_comb begin : step
			logic [RW-1:0] remx;
			logic [RW-1:0] trial;
			rem_n  = rem_s[g];
			root_n = root_s[g];
			val_n  = val_s[g];
			for (int j = 0; j < SQ_PER_STAGE; j++) begin
				if (g * SQ_PER_STAGE + j < ROOT_BITS) begin
					remx  = {rem_n[RW-3:0], val_n[VW-1 -: 2]};
					val_n = {val_n[VW-3:0], 2'b00};
					trial = {1'b0, root_n, 2'b01};
					if (remx >= trial) begin
						rem_n  = remx - trial;
						root_n = {root_n[ROOT_BITS-2:0], 1'b1};
					end else begin
						rem_n  = remx;
						root_n = {root_n[ROOT_BITS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= rem_n;
			root_s[g+1] <= root_n;
			val_s[g+1]  <= val_n;
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid     = vld_s[SQ_STAGES];
	assign out_data.len  = root_s[SQ_STAGES];
	assign out_data.side = side_s[SQ_STAGES];

endmodule

// ===== rtl/rpc_div.sv =====
module rpc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rpc_pkg::dv_in_t  in_data,
	output logic             out_valid,
	output rpc_pkg::dv_out_t out_data
);
	import rpc_pkg::*;

	localparam int RW = ROOT_BITS + 1;

	logic [RW-1:0]         rem_s  [0:DV_STAGES][0:1];
	logic [COORD_BITS-1:0] quo_s  [0:DV_STAGES][0:1];
	logic [COORD_BITS-1:0] num_s  [0:DV_STAGES][0:1];
	logic [ROOT_BITS-1:0]  len_s  [0:DV_STAGES];
	dv_side_t              side_s [0:DV_STAGES];
	logic                  vld_s  [0:DV_STAGES];

	assign rem_s[0][0] = {{(RW - COORD_BITS){1'b0}}, in_data.num_x[PROD_BITS-1:COORD_BITS]};
	assign rem_s[0][1] = {{(RW - COORD_BITS){1'b0}}, in_data.num_y[PROD_BITS-1:COORD_BITS]};
	assign num_s[0][0] = in_data.num_x[COORD_BITS-1:0];
	assign num_s[0][1] = in_data.num_y[COORD_BITS-1:0];
	assign quo_s[0][0] = '0;
	assign quo_s[0][1] = '0;
	assign len_s[0]    = in_data.len;
	assign side_s[0]   = in_data.side;
	assign vld_s[0]    = in_valid;

	for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [RW-1:0]         rem_n;
			logic [COORD_BITS-1:0] quo_n;
			logic [COORD_BITS-1:0] num_n;

			always_comb begin : step
				logic [RW-1:0] remx;
				rem_n = rem_s[g][l];
				quo_n = quo_s[g][l];
				num_n = num_s[g][l];
				for (int j = 0; j < DV_PER_STAGE; j++) begin
					if (g * DV_PER_STAGE + j < COORD_BITS) begin
						remx  = {rem_n[RW-2:0], num_n[COORD_BITS-1]};
						num_n = {num_n[COORD_BITS-2:0], 1'b0};
						if (remx >= {1'b0, len_s[g]}) begin
							rem_n = remx - {1'b0, len_s[g]};
							quo_n = {quo_n[COORD_BITS-2:0], 1'b1};
						end else begin
							rem_n = remx;
							quo_n = {quo_n[COORD_BITS-2:0], 1'b0};
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				rem_s[g+1][l] <= rem_n;
				quo_s[g+1][l] <= quo_n;
				num_s[g+1][l] <= num_n;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			len_s[g+1]  <= len_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid     = vld_s[DV_STAGES];
	assign out_data.qx   = quo_s[DV_STAGES][0];
	assign out_data.qy   = quo_s[DV_STAGES][1];
	assign out_data.side = side_s[DV_STAGES];

endmodule

// ===== rtl/retreat_point_calculator.sv =====
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------------
// command   | start, busy               | item (origin, danger, distance)
// result    | done (one-cycle strobe)   | result (result_x, result_y)
// config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// one item per cycle, busy is never raised; after its start transfer each result
// passes through the three input stages,
// the seven square-root stages (three root bits each), the product stage,
// the five divider stages (four quotient bits each) and the clamp stage.
// arst_n clears all valid bits and loads the register defaults.
// results cannot be held off by the receiver, so the pipeline never stalls.
module retreat_point_calculator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  rpc_pkg::in_item_t           item,
	output logic                        done,
	output rpc_pkg::out_item_t          result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [rpc_pkg::COORD_BITS-1:0] cfg_data
);
	import rpc_pkg::*;

	localparam int PW = COORD_BITS + 3;

	logic [COORD_BITS-1:0]  map_width_q;
	logic [COORD_BITS-1:0]  map_height_q;
	logic [MARGIN_BITS-1:0] edge_margin_q;
	logic                   first_side_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= COORD_BITS'(4096);
			map_height_q  <= COORD_BITS'(4096);
			edge_margin_q <= '0;
			first_side_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_MAP_WIDTH:   map_width_q   <= cfg_data;
				REG_MAP_HEIGHT:  map_height_q  <= cfg_data;
				REG_EDGE_MARGIN: edge_margin_q <= cfg_data[MARGIN_BITS-1:0];
				REG_FIRST_SIDE:  first_side_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: differences
	logic     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	sq_side_t side_s1, side_s2, side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.ox        <= item.origin_x;
		side_s1.oy        <= item.origin_y;
		side_s1.move_dist <= item.move_distance;
		side_s1.sx   <= item.origin_x < item.danger_x;
		side_s1.sy   <= item.origin_y < item.danger_y;
		side_s1.ax   <= (item.origin_x < item.danger_x) ? item.danger_x - item.origin_x
		                                                : item.origin_x - item.danger_x;
		side_s1.ay   <= (item.origin_y < item.danger_y) ? item.danger_y - item.origin_y
		                                                : item.origin_y - item.danger_y;
		side_s1.side <= first_side_q;
	end

	// stage 2: squares
	logic [PROD_BITS-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk) begin
		sqx_s2  <= side_s1.ax * side_s1.ax;
		sqy_s2  <= side_s1.ay * side_s1.ay;
		side_s2 <= side_s1;
	end

	// stage 3: sum of squares
	logic [SQ_VAL_BITS-1:0] sum_s3;

	always_ff @(posedge clk) begin
		sum_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		side_s3 <= side_s2;
	end

	sq_in_t  sq_in;
	sq_out_t sq_out;
	logic    sq_vld;

	assign sq_in.val  = sum_s3;
	assign sq_in.side = side_s3;

	rpc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_data  (sq_in),
		.out_valid(sq_vld),
		.out_data (sq_out)
	);

	// stage 4: numerators with the coincident-point fallback
	dv_in_t dv_in_s4;
	logic   zero_len;

	assign zero_len = (sq_out.len == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		dv_in_s4.side.ox <= sq_out.side.ox;
		dv_in_s4.side.oy <= sq_out.side.oy;
		if (zero_len) begin
			dv_in_s4.num_x   <= {{COORD_BITS{1'b0}}, sq_out.side.move_dist};
			dv_in_s4.num_y   <= '0;
			dv_in_s4.len     <= ROOT_BITS'(1);
			dv_in_s4.side.sx <= sq_out.side.side;
			dv_in_s4.side.sy <= 1'b0;
		end else begin
			dv_in_s4.num_x   <= sq_out.side.ax * sq_out.side.move_dist;
			dv_in_s4.num_y   <= sq_out.side.ay * sq_out.side.move_dist;
			dv_in_s4.len     <= sq_out.len;
			dv_in_s4.side.sx <= sq_out.side.sx;
			dv_in_s4.side.sy <= sq_out.side.sy;
		end
	end

	dv_out_t dv_out;
	logic    dv_vld;

	rpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s4),
		.in_data  (dv_in_s4),
		.out_valid(dv_vld),
		.out_data (dv_out)
	);

	// stage 5: displacement and clamp
	logic signed [PW-1:0] px, py, lo, hix, hiy;
	logic signed [PW-1:0] cx, cy;

	always_comb begin
		px = dv_out.side.sx ? $signed({3'b000, dv_out.side.ox}) - $signed({3'b000, dv_out.qx})
		                    : $signed({3'b000, dv_out.side.ox}) + $signed({3'b000, dv_out.qx});
		py = dv_out.side.sy ? $signed({3'b000, dv_out.side.oy}) - $signed({3'b000, dv_out.qy})
		                    : $signed({3'b000, dv_out.side.oy}) + $signed({3'b000, dv_out.qy});
		lo  = $signed({4'b0000, edge_margin_q});
		hix = $signed({3'b000, map_width_q}) - lo;
		hiy = $signed({3'b000, map_height_q}) - lo;
		if (hix < lo) begin
			hix = lo;
		end
		if (hiy < lo) begin
			hiy = lo;
		end
		cx = px;
		if (cx < lo) begin
			cx = lo;
		end
		if (cx > hix) begin
			cx = hix;
		end
		cy = py;
		if (cy < lo) begin
			cy = lo;
		end
		if (cy > hiy) begin
			cy = hiy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.result_x <= cx[COORD_BITS-1:0];
		result.result_y <= cy[COORD_BITS-1:0];
	end

	assign done = vld_s5;

endmodule

// ===== rtl/rpc_checker.sv =====
module rpc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready
);
	import rpc_pkg::*;

	logic acc;

	assign acc = start && !busy;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LATENCY done)
		else $error("transfer did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, LATENCY))
		else $error("result without a matching transfer");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("command refused");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind retreat_point_calculator rpc_checker u_rpc_checker (.*);
